[src/lsht_pkg.sv]
// ----------------------------------------------------------------------------
// lsht_pkg
// Shared types and constants of the line segment hit test core.
// ----------------------------------------------------------------------------
`default_nettype none

package lsht_pkg;

  // coordinate format
  localparam int COORD_W      = 20;
  localparam int COORD_FRAC   = 16;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int TOL_W        = 24;
  localparam int TOL_FRAC     = 16;

  // segment table
  localparam int MAX_SEGMENTS = 256;
  localparam int IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int CNT_W        = IDX_W + 1;

  // config port
  localparam int CFG_IDX_W    = 1;
  localparam int LCNT_W       = 9;

  // stream payload
  localparam int SLOT_W       = 8;
  localparam int OP_W         = 2;
  localparam int HIT_IDX_W    = 9;
  localparam int IN_DATA_W    = 128;
  localparam int OUT_DATA_W   = 16;

  // shared unit
  localparam int MUL_W        = 24;
  localparam int PROD_W       = 2 * MUL_W;
  localparam int ACC_W        = 72;
  localparam int HI_SHIFT     = 22;
  localparam int DEN_W        = 42;
  localparam int NUM_W        = 43;
  localparam int REM_W        = 64;
  localparam int QB           = 23;
  localparam int QUO_W        = QB + 1;
  localparam int STEP_W       = $clog2(QB);

  // scale factors
  localparam int LINE_SCALE2  = 40000;
  localparam int POINT_SCALE  = 2000;
  localparam int EPS_INV      = 1000;
  localparam int EPS_LIM      = ((1 << COORD_FRAC) - 1) / EPS_INV + 1;
  localparam int DIST_SH      = 2 * COORD_FRAC - TOL_FRAC;
  localparam int BOX_SH       = COORD_FRAC - TOL_FRAC;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE = 2'd0,
    OP_LINE  = 2'd1,
    OP_POINT = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_COUNT = 1'd0,
    REG_PICK_TOL   = 1'd1
  } reg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] by;
    logic signed [COORD_W-1:0] bx;
    logic signed [COORD_W-1:0] ay;
    logic signed [COORD_W-1:0] ax;
  } seg_t;

  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_MUL,
    ALU_MAC,
    ALU_MACH,
    ALU_DIVI,
    ALU_DIVS
  } alu_op_t;

  typedef struct packed {
    alu_op_t                   op;
    logic signed [MUL_W-1:0]   a;
    logic signed [MUL_W-1:0]   b;
  } alu_ctrl_t;

endpackage

`default_nettype wire

[src/lsht_alu.sv]
// ----------------------------------------------------------------------------
// lsht_alu
// Shared multiply-accumulate and restoring divider, one step per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lsht_alu (
  input  wire logic                               clk,
  input  wire lsht_pkg::alu_ctrl_t                ctrl,
  input  wire logic [lsht_pkg::DEN_W-1:0]         den,
  output logic signed [lsht_pkg::ACC_W-1:0]       acc,
  output logic signed [lsht_pkg::QUO_W-1:0]       quo
);
  import lsht_pkg::*;

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_abs;
  logic [REM_W-1:0]         rem;
  logic [REM_W-1:0]         dv;
  logic [REM_W:0]           diff;
  logic [QB-1:0]            q;
  logic                     neg;

  assign prod     = ctrl.a * ctrl.b;
  assign prod_ext = ACC_W'(prod);
  assign acc_abs  = acc[ACC_W-1] ? -acc : acc;
  assign diff     = {1'b0, rem} - {1'b0, dv};
  assign quo      = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});

  always_ff @(posedge clk) begin
    unique case (ctrl.op)
      ALU_NOP: begin
      end
      ALU_MUL: begin
        acc <= prod_ext;
      end
      ALU_MAC: begin
        acc <= acc + prod_ext;
      end
      ALU_MACH: begin
        acc <= acc + (prod_ext <<< HI_SHIFT);
      end
      ALU_DIVI: begin
        // rounding to nearest: add half the divisor to the magnitude
        rem <= acc_abs[REM_W-1:0] + REM_W'(den >> 1);
        dv  <= REM_W'(den) << (QB - 1);
        q   <= '0;
        neg <= acc[ACC_W-1];
      end
      ALU_DIVS: begin
        if (!diff[REM_W]) begin
          rem <= diff[REM_W-1:0];
          q   <= {q[QB-2:0], 1'b1};
        end else begin
          q   <= {q[QB-2:0], 1'b0};
        end
        dv <= dv >> 1;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[src/line_segment_hit_test_core.sv]
// ----------------------------------------------------------------------------
// line_segment_hit_test_core
// Segment table with line and endpoint pick queries over a shared unit.
// ----------------------------------------------------------------------------
// Writes are taken in the idle state. A query walks the table one segment at
// a time through a single shared multiplier/accumulator and a one-bit-per-cycle
// divider; an endpoint query tests both endpoints of each segment, a line
// query also finds the foot point with two 23-step divisions (skipped for
// near-horizontal or near-vertical segments), and a box miss ends a segment
// early. The input is not ready while a query runs. A finished result waits
// in an output register; a following query that finishes before that result
// is taken holds in its last state.
`default_nettype none

module line_segment_hit_test_core (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  // slot, start_x, start_y, end_x, end_y, touch_x, touch_y
  input  wire logic [lsht_pkg::IN_DATA_W-1:0]       s_tdata,
  // op
  input  wire logic [lsht_pkg::OP_W-1:0]            s_tuser,
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // hit_index, zero padding
  output logic [lsht_pkg::OUT_DATA_W-1:0]           m_tdata,
  // hit
  output logic                                      m_tuser,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [lsht_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [lsht_pkg::TOL_W-1:0]           cfg_data
);
  import lsht_pkg::*;

  localparam int NS = 26;

  typedef enum logic [NS-1:0] {
    S_IDLE  = NS'(1) << 0,
    S_RD    = NS'(1) << 1,
    S_LD    = NS'(1) << 2,
    S_CLASS = NS'(1) << 3,
    S_DEN0  = NS'(1) << 4,
    S_DEN1  = NS'(1) << 5,
    S_N0    = NS'(1) << 6,
    S_N1    = NS'(1) << 7,
    S_NSAVE = NS'(1) << 8,
    S_NX0   = NS'(1) << 9,
    S_NX1   = NS'(1) << 10,
    S_DIVI  = NS'(1) << 11,
    S_DIVS  = NS'(1) << 12,
    S_FOOT  = NS'(1) << 13,
    S_BOX0  = NS'(1) << 14,
    S_BOX1  = NS'(1) << 15,
    S_BOX2  = NS'(1) << 16,
    S_BOX3  = NS'(1) << 17,
    S_BOX4  = NS'(1) << 18,
    S_SQ0   = NS'(1) << 19,
    S_SQ1   = NS'(1) << 20,
    S_DSAVE = NS'(1) << 21,
    S_DHI   = NS'(1) << 22,
    S_DCMP  = NS'(1) << 23,
    S_NEXT  = NS'(1) << 24,
    S_DONE  = NS'(1) << 25
  } state_t;

  state_t state;

  // config registers
  logic [LCNT_W-1:0] line_count;
  logic [TOL_W-1:0]  pick_tolerance;

  // request fields
  op_t                       in_op;
  logic [SLOT_W-1:0]         in_slot;
  seg_t                      in_seg;
  logic signed [COORD_W-1:0] in_tx;
  logic signed [COORD_W-1:0] in_ty;

  // segment table
  seg_t mem [MAX_SEGMENTS];
  seg_t rdata;

  // query state
  op_t                       qop;
  logic [CNT_W-1:0]          cnt;
  logic [CNT_W-1:0]          idx;
  logic signed [COORD_W-1:0] px;
  logic signed [COORD_W-1:0] py;
  seg_t                      seg;
  logic signed [DIFF_W-1:0]  dx;
  logic signed [DIFF_W-1:0]  dy;
  logic [DEN_W-1:0]          den;
  logic signed [NUM_W-1:0]   num;
  logic signed [MUL_W-1:0]   fx;
  logic signed [MUL_W-1:0]   fy;
  logic [MUL_W-1:0]          d2hi;
  logic [STEP_W-1:0]         step;
  logic                      yaxis;
  logic                      second;
  logic                      hit;
  logic [HIT_IDX_W-1:0]      hit_index;

  // output register
  logic                      out_valid;
  logic                      out_hit;
  logic [HIT_IDX_W-1:0]      out_index;

  // shared unit
  alu_ctrl_t               ctrl;
  logic signed [ACC_W-1:0] acc;
  logic signed [QUO_W-1:0] quo;

  logic [DIFF_W-1:0]         adx;
  logic [DIFF_W-1:0]         ady;
  logic signed [COORD_W-1:0] xlo, xhi, ylo, yhi;
  logic signed [ACC_W-1:0]   tol_box;
  logic signed [ACC_W-1:0]   tol_box_neg;
  logic signed [ACC_W-1:0]   tol_dist;
  logic signed [MUL_W-1:0]   scale;
  logic signed [MUL_W-1:0]   dsel;
  logic [CNT_W-1:0]          cnt_lim;

  assign in_op   = op_t'(s_tuser);
  assign in_slot = s_tdata[SLOT_W-1:0];
  assign in_seg.ax = s_tdata[SLOT_W +: COORD_W];
  assign in_seg.ay = s_tdata[SLOT_W + COORD_W +: COORD_W];
  assign in_seg.bx = s_tdata[SLOT_W + 2*COORD_W +: COORD_W];
  assign in_seg.by = s_tdata[SLOT_W + 3*COORD_W +: COORD_W];
  assign in_tx     = s_tdata[SLOT_W + 4*COORD_W +: COORD_W];
  assign in_ty     = s_tdata[SLOT_W + 5*COORD_W +: COORD_W];

  assign s_tready  = (state == S_IDLE);
  assign m_tvalid  = out_valid;
  assign m_tdata   = OUT_DATA_W'(out_index);
  assign m_tuser   = out_hit;
  assign cfg_ready = 1'b1;

  assign adx = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
  assign ady = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
  assign xlo = (seg.ax < seg.bx) ? seg.ax : seg.bx;
  assign xhi = (seg.ax < seg.bx) ? seg.bx : seg.ax;
  assign ylo = (seg.ay < seg.by) ? seg.ay : seg.by;
  assign yhi = (seg.ay < seg.by) ? seg.by : seg.ay;

  assign tol_box     = $signed(ACC_W'(pick_tolerance) << BOX_SH);
  assign tol_box_neg = -tol_box;
  assign tol_dist    = $signed(ACC_W'(pick_tolerance) << DIST_SH);
  assign scale       = (qop == OP_LINE) ? MUL_W'(LINE_SCALE2) : MUL_W'(POINT_SCALE);
  assign dsel        = yaxis ? MUL_W'(dy) : MUL_W'(dx);
  assign cnt_lim     = (32'(line_count) > MAX_SEGMENTS) ? CNT_W'(MAX_SEGMENTS)
                                                        : CNT_W'(line_count);

  lsht_alu u_alu (
    .clk  (clk),
    .ctrl (ctrl),
    .den  (den),
    .acc  (acc),
    .quo  (quo)
  );

  // operand selection for the shared unit
  always_comb begin
    ctrl.op = ALU_NOP;
    ctrl.a  = '0;
    ctrl.b  = '0;
    unique case (state)
      S_DEN0: begin
        ctrl.op = ALU_MUL; ctrl.a = MUL_W'(dx); ctrl.b = MUL_W'(dx);
      end
      S_DEN1: begin
        ctrl.op = ALU_MAC; ctrl.a = MUL_W'(dy); ctrl.b = MUL_W'(dy);
      end
      S_N0: begin
        ctrl.op = ALU_MUL; ctrl.a = MUL_W'(px) - MUL_W'(seg.ax); ctrl.b = MUL_W'(dx);
      end
      S_N1: begin
        ctrl.op = ALU_MAC; ctrl.a = MUL_W'(py) - MUL_W'(seg.ay); ctrl.b = MUL_W'(dy);
      end
      S_NX0: begin
        ctrl.op = ALU_MUL; ctrl.a = dsel; ctrl.b = $signed(MUL_W'(num[HI_SHIFT-1:0]));
      end
      S_NX1: begin
        ctrl.op = ALU_MACH; ctrl.a = dsel;
        ctrl.b = MUL_W'($signed(num[NUM_W-1:HI_SHIFT]));
      end
      S_DIVI: ctrl.op = ALU_DIVI;
      S_DIVS: ctrl.op = ALU_DIVS;
      S_BOX0: begin
        ctrl.op = ALU_MUL; ctrl.a = fx - MUL_W'(xlo); ctrl.b = scale;
      end
      S_BOX1: begin
        ctrl.op = ALU_MUL; ctrl.a = fx - MUL_W'(xhi); ctrl.b = scale;
      end
      S_BOX2: begin
        ctrl.op = ALU_MUL; ctrl.a = fy - MUL_W'(ylo); ctrl.b = scale;
      end
      S_BOX3: begin
        ctrl.op = ALU_MUL; ctrl.a = fy - MUL_W'(yhi); ctrl.b = scale;
      end
      S_SQ0: begin
        ctrl.op = ALU_MUL; ctrl.a = fx - MUL_W'(px); ctrl.b = fx - MUL_W'(px);
      end
      S_SQ1: begin
        ctrl.op = ALU_MAC; ctrl.a = fy - MUL_W'(py); ctrl.b = fy - MUL_W'(py);
      end
      S_DSAVE: begin
        ctrl.op = ALU_MUL; ctrl.a = $signed(MUL_W'(acc[HI_SHIFT-1:0])); ctrl.b = scale;
      end
      S_DHI: begin
        ctrl.op = ALU_MACH; ctrl.a = $signed(d2hi); ctrl.b = scale;
      end
      default: begin
      end
    endcase
  end

  // segment table, registered read
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready && in_op == OP_WRITE && 32'(in_slot) < MAX_SEGMENTS) begin
      mem[in_slot[IDX_W-1:0]] <= in_seg;
    end
    rdata <= mem[idx[IDX_W-1:0]];
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      line_count     <= '0;
      pick_tolerance <= TOL_W'(327680);
    end else if (cfg_valid && cfg_ready) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LINE_COUNT: line_count     <= cfg_data[LCNT_W-1:0];
        REG_PICK_TOL:   pick_tolerance <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        px  <= in_tx;
        py  <= in_ty;
        qop <= in_op;
        cnt <= cnt_lim;
      end
      S_LD: begin
        seg    <= rdata;
        dx     <= DIFF_W'(rdata.bx) - DIFF_W'(rdata.ax);
        dy     <= DIFF_W'(rdata.by) - DIFF_W'(rdata.ay);
        fx     <= MUL_W'(rdata.ax);
        fy     <= MUL_W'(rdata.ay);
        yaxis  <= 1'b0;
        second <= 1'b0;
      end
      S_CLASS: begin
        if (ady < DIFF_W'(EPS_LIM)) begin
          fx <= MUL_W'(px);
          fy <= MUL_W'(seg.ay);
        end else if (adx < DIFF_W'(EPS_LIM)) begin
          fx <= MUL_W'(seg.ax);
          fy <= MUL_W'(py);
        end
      end
      S_N0:    den  <= acc[DEN_W-1:0];
      S_NSAVE: num  <= acc[NUM_W-1:0];
      S_DIVI:  step <= '0;
      S_DIVS:  step <= step + STEP_W'(1);
      S_FOOT: begin
        if (!yaxis) begin
          fx    <= MUL_W'(seg.ax) + quo;
          yaxis <= 1'b1;
        end else begin
          fy <= MUL_W'(seg.ay) + quo;
        end
      end
      S_DSAVE: d2hi <= MUL_W'(acc[HI_SHIFT +: MUL_W]);
      S_DCMP: begin
        if (qop == OP_POINT && !second) begin
          second <= 1'b1;
          fx     <= MUL_W'(seg.bx);
          fy     <= MUL_W'(seg.by);
        end
      end
      default: begin
      end
    endcase
  end

  // result register, frees the sequencer while a result waits
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      out_hit   <= 1'b0;
      out_index <= '0;
    end else if (state == S_DONE && (!out_valid || m_tready)) begin
      out_valid <= 1'b1;
      out_hit   <= hit;
      out_index <= hit_index;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      hit       <= 1'b0;
      hit_index <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            idx       <= '0;
            hit       <= 1'b0;
            hit_index <= '0;
            if (in_op == OP_LINE || in_op == OP_POINT) begin
              state <= (cnt_lim == '0) ? S_DONE : S_RD;
            end
          end
        end
        S_RD:    state <= S_LD;
        S_LD:    state <= (qop == OP_LINE) ? S_CLASS : S_SQ0;
        S_CLASS: begin
          if (ady < DIFF_W'(EPS_LIM) || adx < DIFF_W'(EPS_LIM)) state <= S_BOX0;
          else                                                  state <= S_DEN0;
        end
        S_DEN0:  state <= S_DEN1;
        S_DEN1:  state <= S_N0;
        S_N0:    state <= S_N1;
        S_N1:    state <= S_NSAVE;
        S_NSAVE: state <= S_NX0;
        S_NX0:   state <= S_NX1;
        S_NX1:   state <= S_DIVI;
        S_DIVI:  state <= S_DIVS;
        S_DIVS: begin
          if (step == STEP_W'(QB - 1)) state <= S_FOOT;
        end
        S_FOOT:  state <= yaxis ? S_BOX0 : S_NX0;
        S_BOX0:  state <= S_BOX1;
        S_BOX1:  state <= (acc < tol_box_neg) ? S_NEXT : S_BOX2;
        S_BOX2:  state <= (acc > tol_box) ? S_NEXT : S_BOX3;
        S_BOX3:  state <= (acc < tol_box_neg) ? S_NEXT : S_BOX4;
        S_BOX4:  state <= (acc > tol_box) ? S_NEXT : S_SQ0;
        S_SQ0:   state <= S_SQ1;
        S_SQ1:   state <= S_DSAVE;
        S_DSAVE: state <= S_DHI;
        S_DHI:   state <= S_DCMP;
        S_DCMP: begin
          if (qop == OP_LINE) begin
            if (acc <= tol_dist) begin
              hit       <= 1'b1;
              hit_index <= HIT_IDX_W'(idx);
            end
            state <= S_NEXT;
          end else begin
            // endpoint index is segment times two plus endpoint
            if (acc < tol_dist) begin
              hit       <= 1'b1;
              hit_index <= HIT_IDX_W'({idx, second});
            end
            state <= second ? S_NEXT : S_SQ0;
          end
        end
        S_NEXT: begin
          idx   <= idx + CNT_W'(1);
          state <= (idx + CNT_W'(1) == cnt) ? S_DONE : S_RD;
        end
        S_DONE: begin
          if (!out_valid || m_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire
